/* rtl/core/ovtm_pkg.sv */
// ----------------------------------------------------------------------------
// ovtm_pkg
// Shared types, register indexes and constants of the over-temperature monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ovtm_pkg;

    // Filter framing
    localparam int unsigned IDX_W = 5;
    localparam logic [IDX_W-1:0] SAMPLES_PER_READING = 5'd20;
    localparam logic [IDX_W-1:0] DROPPED_SAMPLES     = 5'd2;
    localparam int unsigned      AVG_SHIFT           = 4;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned SUM_W    = 17;
    localparam int unsigned MV_W     = 13;
    localparam int unsigned TICK_W   = 24;
    localparam int unsigned COUNT_W  = 4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;
    localparam logic [TICK_W-1:0]   TIMER_MAX  = 24'hFFFFFF;

    // avg * 12 / 10 done as avg * ceil(12 * 2^19 / 10) >> 19, exact for 12-bit avg
    localparam int unsigned        MV_RECIP_W = 20;
    localparam int unsigned        MV_SHIFT   = 19;
    localparam logic [MV_RECIP_W-1:0] MV_RECIP = 20'd629146;
    localparam int unsigned        PROD_W     = SAMPLE_W + MV_RECIP_W;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM       = 2'd2;

    localparam logic [MV_W-1:0]    RST_HOT_THRESHOLD = 13'd2000;
    localparam logic [TICK_W-1:0]  RST_HOLD_TICKS    = 24'd300000;
    localparam logic [COUNT_W-1:0] RST_CONFIRM       = 4'd10;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_HOT     = 2'd1,
        ST_LATCHED = 2'd2
    } t_therm;

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [1:0]      temp_state;
        logic            reading_valid;
        logic [MV_W-1:0] reading_mv;
        logic            confirming;
    } t_out_word;

    // Filter result handed to the thermal state machine
    typedef struct packed {
        logic            operation;
        logic            reading_valid;
        logic [MV_W-1:0] reading_mv;
    } t_reading;

    typedef struct packed {
        logic [MV_W-1:0]    hot_threshold_mv;
        logic [TICK_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] confirm_readings;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/core/ovtm_filter.sv */
// ----------------------------------------------------------------------------
// ovtm_filter
// Trimmed-mean filter: accumulate a group of samples, scale to millivolts.
// ----------------------------------------------------------------------------
`default_nettype none

module ovtm_filter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load1,
    input  wire ovtm_pkg::t_in_word i_word,
    input  wire logic              i_load2,
    output ovtm_pkg::t_reading     o_reading
);

    logic [ovtm_pkg::IDX_W-1:0]    r_idx;
    logic [ovtm_pkg::SUM_W-1:0]    r_sum;
    logic [ovtm_pkg::SAMPLE_W-1:0] r_max;
    logic [ovtm_pkg::SAMPLE_W-1:0] r_min;

    logic [ovtm_pkg::IDX_W-1:0]    n_idx;
    logic [ovtm_pkg::SUM_W-1:0]    n_sum;
    logic [ovtm_pkg::SAMPLE_W-1:0] n_max;
    logic [ovtm_pkg::SAMPLE_W-1:0] n_min;
    logic [ovtm_pkg::SUM_W-1:0]    w_trim;
    logic                          w_done;

    logic                          r_s2_op;
    logic                          r_s2_rv;
    logic [ovtm_pkg::SAMPLE_W-1:0] r_s2_avg;
    logic [ovtm_pkg::PROD_W-1:0]   w_prod;
    ovtm_pkg::t_reading            r_s3;

    always_comb begin
        n_idx  = r_idx;
        n_sum  = r_sum;
        n_max  = r_max;
        n_min  = r_min;
        w_done = 1'b0;
        if (i_word.operation == ovtm_pkg::OP_SAMPLE) begin
            if (r_idx >= ovtm_pkg::DROPPED_SAMPLES) begin
                if (i_word.sample > r_max) begin
                    n_max = i_word.sample;
                end
                if (i_word.sample < r_min) begin
                    n_min = i_word.sample;
                end
                n_sum = r_sum + {{(ovtm_pkg::SUM_W-ovtm_pkg::SAMPLE_W){1'b0}}, i_word.sample};
            end
            n_idx  = r_idx + 1'b1;
            w_done = (r_idx == ovtm_pkg::SAMPLES_PER_READING - 1'b1);
        end
        // Drop largest and smallest of the kept samples
        w_trim = n_sum
               - {{(ovtm_pkg::SUM_W-ovtm_pkg::SAMPLE_W){1'b0}}, n_max}
               - {{(ovtm_pkg::SUM_W-ovtm_pkg::SAMPLE_W){1'b0}}, n_min};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_sum <= '0;
            r_max <= '0;
            r_min <= ovtm_pkg::SAMPLE_MAX;
        end else if (i_load1) begin
            if (w_done) begin
                r_idx <= '0;
                r_sum <= '0;
                r_max <= '0;
                r_min <= ovtm_pkg::SAMPLE_MAX;
            end else begin
                r_idx <= n_idx;
                r_sum <= n_sum;
                r_max <= n_max;
                r_min <= n_min;
            end
        end
    end

    // Stage 2: trimmed average (zero when no reading completes)
    always_ff @(posedge i_clk) begin
        if (i_load1) begin
            r_s2_op  <= i_word.operation;
            r_s2_rv  <= w_done;
            r_s2_avg <= w_done ? w_trim[ovtm_pkg::AVG_SHIFT +: ovtm_pkg::SAMPLE_W] : '0;
        end
    end

    // Stage 3: scale to millivolts
    assign w_prod = r_s2_avg * ovtm_pkg::MV_RECIP;

    always_ff @(posedge i_clk) begin
        if (i_load2) begin
            r_s3.operation     <= r_s2_op;
            r_s3.reading_valid <= r_s2_rv;
            r_s3.reading_mv    <= w_prod[ovtm_pkg::MV_SHIFT +: ovtm_pkg::MV_W];
        end
    end

    assign o_reading = r_s3;

endmodule

`default_nettype wire

/* rtl/core/ovtm_thermal.sv */
// ----------------------------------------------------------------------------
// ovtm_thermal
// Thermal state machine: confirmation counting, hold timer and latch.
// ----------------------------------------------------------------------------
`default_nettype none

module ovtm_thermal (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire ovtm_pkg::t_reading i_reading,
    input  wire ovtm_pkg::t_cfg     i_cfg,
    output ovtm_pkg::t_therm        o_state,
    output ovtm_pkg::t_therm        o_state_next,
    output logic                    o_confirm_next
);

    ovtm_pkg::t_therm                r_state;
    ovtm_pkg::t_therm                n_state;
    logic                            r_active;
    logic                            n_active;
    logic [ovtm_pkg::COUNT_W-1:0]    r_count;
    logic [ovtm_pkg::COUNT_W-1:0]    n_count;
    logic [ovtm_pkg::TICK_W-1:0]     r_timer;
    logic [ovtm_pkg::TICK_W-1:0]     n_timer;
    logic                            r_running;
    logic                            n_running;

    logic [ovtm_pkg::COUNT_W-1:0]    w_need;
    logic [ovtm_pkg::COUNT_W-1:0]    w_count_inc;
    logic                            w_above;
    logic                            w_below;
    logic                            w_step_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ovtm_pkg::ST_NORMAL;
            r_active  <= 1'b0;
            r_count   <= '0;
            r_timer   <= '0;
            r_running <= 1'b0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_count   <= n_count;
            r_timer   <= n_timer;
            r_running <= n_running;
        end
    end

    always_comb begin
        w_need      = (i_cfg.confirm_readings == '0) ? 4'd1 : i_cfg.confirm_readings;
        w_count_inc = r_count + 1'b1;
        w_above     = i_reading.reading_mv > i_cfg.hot_threshold_mv;
        w_below     = i_reading.reading_mv < i_cfg.hot_threshold_mv;
        w_step_done = !w_above && (w_count_inc >= w_need);

        n_state   = r_state;
        n_active  = r_active;
        n_count   = r_count;
        n_timer   = r_timer;
        n_running = r_running;

        if (i_reading.operation == ovtm_pkg::OP_TICK) begin
            if (r_running && (r_timer != ovtm_pkg::TIMER_MAX)) begin
                n_timer = r_timer + 1'b1;
            end
        end else if (i_reading.reading_valid) begin
            case (r_state)
                ovtm_pkg::ST_NORMAL: begin
                    if (!r_active) begin
                        if (w_below) begin
                            n_active = 1'b1;
                            n_count  = '0;
                        end
                    end else if (w_above) begin
                        n_active = 1'b0;
                        n_count  = '0;
                    end else if (w_step_done) begin
                        n_active  = 1'b0;
                        n_count   = '0;
                        n_state   = ovtm_pkg::ST_HOT;
                        n_timer   = '0;
                        n_running = 1'b1;
                    end else begin
                        n_count = w_count_inc;
                    end
                end
                ovtm_pkg::ST_HOT: begin
                    if (r_timer >= i_cfg.hold_ticks) begin
                        if (!r_active) begin
                            n_active = 1'b1;
                            n_count  = '0;
                        end else if (w_above) begin
                            n_active = 1'b0;
                            n_count  = '0;
                        end else if (w_step_done) begin
                            n_active  = 1'b0;
                            n_count   = '0;
                            n_state   = ovtm_pkg::ST_LATCHED;
                            n_timer   = '0;
                            n_running = 1'b0;
                        end else begin
                            n_count = w_count_inc;
                        end
                    end
                end
                default: begin
                    // latched: hold everything until reset
                end
            endcase
        end
    end

    assign o_state        = r_state;
    assign o_state_next   = n_state;
    assign o_confirm_next = n_active;

endmodule

`default_nettype wire

/* rtl/core/overtemp_trimmed_mean_monitor.sv */
// ----------------------------------------------------------------------------
// overtemp_trimmed_mean_monitor
// Thermistor over-temperature monitor with a trimmed-mean reading filter.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_word): one word per ADC sample
// (operation 0) or timer tick (operation 1). Every input word gives exactly one
// output word (o_out_valid / i_out_ready / o_out_word): the thermal state after
// that word, a reading flag and millivolt value when a group of 20 samples
// completes, and the confirmation flag.
// Path: an accepted word passes through the input register, filter accumulate,
// millivolt scaling and state update stages, each of which a stall can hold.
// Throughput: one word per cycle when not stalled; the four stage registers
// pass a word each such cycle, and filter and thermal state act once per word.
// Stall: a stage refills when empty or when its word moves on; with all stages
// full and the receiver stalled, o_in_ready drops and the output word holds.
// Reset (i_rst_n low, synchronous): pipeline empties, filter restarts its group,
// state goes to normal with no confirmation and the hold timer stops.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 threshold mV, 1 hold ticks, 2 confirm count) at once.
// ----------------------------------------------------------------------------
`default_nettype none

module overtemp_trimmed_mean_monitor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire ovtm_pkg::t_in_word                  i_in_word,
    // output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output ovtm_pkg::t_out_word                      o_out_word,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [ovtm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ovtm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    ovtm_pkg::t_cfg      r_cfg;

    // Stage valid bits: 1 input, 2 average, 3 millivolts, 4 output
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic                r_v4;
    logic                w_a1;
    logic                w_a2;
    logic                w_a3;
    logic                w_a4;

    ovtm_pkg::t_in_word  r_s1;
    ovtm_pkg::t_reading  w_reading;
    ovtm_pkg::t_out_word r_out;

    ovtm_pkg::t_therm    w_state;
    ovtm_pkg::t_therm    w_state_next;
    logic                w_confirm_next;
    logic                w_fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hot_threshold_mv <= ovtm_pkg::RST_HOT_THRESHOLD;
            r_cfg.hold_ticks       <= ovtm_pkg::RST_HOLD_TICKS;
            r_cfg.confirm_readings <= ovtm_pkg::RST_CONFIRM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ovtm_pkg::CFG_HOT_THRESHOLD: begin
                    r_cfg.hot_threshold_mv <= i_cfg_wdata[ovtm_pkg::MV_W-1:0];
                end
                ovtm_pkg::CFG_HOLD_TICKS: begin
                    r_cfg.hold_ticks <= i_cfg_wdata[ovtm_pkg::TICK_W-1:0];
                end
                ovtm_pkg::CFG_CONFIRM: begin
                    r_cfg.confirm_readings <= i_cfg_wdata[ovtm_pkg::COUNT_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // A stage can take a word when empty or when its word moves on
    assign w_a4 = !r_v4 || i_out_ready;
    assign w_a3 = !r_v3 || w_a4;
    assign w_a2 = !r_v2 || w_a3;
    assign w_a1 = !r_v1 || w_a2;

    assign o_in_ready = w_a1;
    assign w_fire     = r_v3 && w_a4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_a1) begin
                r_v1 <= i_in_valid;
            end
            if (w_a2) begin
                r_v2 <= r_v1;
            end
            if (w_a3) begin
                r_v3 <= r_v2;
            end
            if (w_a4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_a1) begin
            r_s1 <= i_in_word;
        end
    end

    ovtm_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load1   (r_v1 && w_a2),
        .i_word    (r_s1),
        .i_load2   (r_v2 && w_a3),
        .o_reading (w_reading)
    );

    ovtm_thermal u_thermal (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_reading      (w_reading),
        .i_cfg          (r_cfg),
        .o_state        (w_state),
        .o_state_next   (w_state_next),
        .o_confirm_next (w_confirm_next)
    );

    // Output register: state after this word
    always_ff @(posedge i_clk) begin
        if (w_a4) begin
            r_out.temp_state    <= w_state_next;
            r_out.reading_valid <= w_reading.reading_valid;
            r_out.reading_mv    <= w_reading.reading_mv;
            r_out.confirming    <= w_confirm_next;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_word  = r_out;

    // A word without a reading carries a zero millivolt field
    a_mv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.reading_valid) |-> (o_out_word.reading_mv == '0))
        else $error("reading_mv nonzero without reading_valid");

    // Latched holds until reset
    a_latch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ovtm_pkg::ST_LATCHED) |=> (w_state == ovtm_pkg::ST_LATCHED))
        else $error("thermal state left latched");

    // No confirmation runs once latched
    a_latch_no_confirm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.temp_state == ovtm_pkg::ST_LATCHED))
            |-> !o_out_word.confirming)
        else $error("confirming reported in latched state");

    // A state change only happens when a word leaves stage 3
    a_state_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(w_state))
        else $error("thermal state moved without a word");

endmodule

`default_nettype wire

/* sim/tb_overtemp_trimmed_mean_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overtemp_trimmed_mean_monitor
// Drives ADC sample and tick words into the over-temperature monitor under
// random source gaps and sink stalls. It predicts every output word with an
// in-bench model of the trimmed-mean filter and the thermal state machine,
// then compares the words field by field. The run walks the register values
// from never-trigger through hot to the permanent latch.
// ----------------------------------------------------------------------------
module tb_overtemp_trimmed_mean_monitor;
    import ovtm_pkg::*;

    localparam int unsigned MV_FULL_SCALE = 4914;
    localparam int unsigned MV_NUM        = 12;
    localparam int unsigned MV_DEN        = 10;
    localparam int unsigned GROUP_SIZE    = 20;

    // ------------------------------------------------------------------
    // Block-level signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HOT_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // ------------------------------------------------------------------
    // Monitor model: configuration copy, filter and thermal state
    // ------------------------------------------------------------------
    logic [MV_W-1:0]     thr_mv       = RST_HOT_THRESHOLD;
    logic [TICK_W-1:0]   hold_limit   = RST_HOLD_TICKS;
    logic [COUNT_W-1:0]  confirm_need = RST_CONFIRM;

    logic [IDX_W-1:0]    flt_index    = '0;
    logic [SUM_W-1:0]    flt_sum      = '0;
    logic [SAMPLE_W-1:0] flt_max      = '0;
    logic [SAMPLE_W-1:0] flt_min      = SAMPLE_MAX;
    t_therm              th_state     = ST_NORMAL;
    logic                cf_active    = 1'b0;
    logic [COUNT_W-1:0]  cf_count     = '0;
    logic [TICK_W-1:0]   hot_timer    = '0;
    logic                hot_timer_on = 1'b0;

    // Status words predicted for accepted input words, oldest first
    t_out_word predicted_status[$];
    t_out_word want;

    int unsigned mismatches    = 0;
    int unsigned readings_seen = 0;
    int unsigned ticks_seen    = 0;
    int unsigned hot_entries   = 0;
    int unsigned latch_entries = 0;
    int unsigned stall_cycles  = 0;

    // Idle rates in percent per cycle, and the sink hold-off request
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;

    overtemp_trimmed_mean_monitor DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Generous fixed bound on the whole run
    initial begin
        #1_000_000;
        $display("tb_overtemp_trimmed_mean_monitor NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model functions
    // ------------------------------------------------------------------

    // Count one reading into an open confirmation; true when it completes.
    // A confirm count of zero behaves like one, and a count already past a
    // lowered setting completes at once (greater-or-equal compare).
    function automatic bit count_confirm(logic [MV_W-1:0] mv);
        logic [COUNT_W-1:0] need;
        need = (confirm_need == '0) ? 4'd1 : confirm_need;
        if (mv > thr_mv) begin
            cf_active = 1'b0;
            cf_count  = '0;
            return 1'b0;
        end
        cf_count = cf_count + 1'b1;
        if (cf_count >= need) begin
            cf_active = 1'b0;
            cf_count  = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void apply_reading(logic [MV_W-1:0] mv);
        case (th_state)
            ST_NORMAL: begin
                // strictly below opens; the opening reading is not counted
                if (!cf_active) begin
                    if (mv < thr_mv) begin
                        cf_active = 1'b1;
                        cf_count  = '0;
                    end
                end else if (count_confirm(mv)) begin
                    th_state     = ST_HOT;
                    hot_timer    = '0;
                    hot_timer_on = 1'b1;
                    hot_entries++;
                end
            end
            ST_HOT: begin
                // ignore readings until the hold time has run out
                if (hot_timer >= hold_limit) begin
                    if (!cf_active) begin
                        cf_active = 1'b1;
                        cf_count  = '0;
                    end else if (count_confirm(mv)) begin
                        th_state     = ST_LATCHED;
                        hot_timer    = '0;
                        hot_timer_on = 1'b0;
                        latch_entries++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the model by one accepted word and return its status word
    function automatic t_out_word monitor_step(t_in_word w);
        t_out_word        r;
        logic [SUM_W-1:0] trimmed;
        int unsigned      avg;
        r = '0;
        if (w.operation == OP_TICK) begin
            if (hot_timer_on && hot_timer < TIMER_MAX)
                hot_timer++;
            ticks_seen++;
        end else begin
            if (flt_index >= DROPPED_SAMPLES) begin
                if (w.sample > flt_max)
                    flt_max = w.sample;
                if (w.sample < flt_min)
                    flt_min = w.sample;
                flt_sum = flt_sum + SUM_W'(w.sample);
            end
            flt_index++;
            if (flt_index >= SAMPLES_PER_READING) begin
                trimmed = flt_sum - SUM_W'(flt_max) - SUM_W'(flt_min);
                avg = trimmed >> AVG_SHIFT;
                r.reading_valid = 1'b1;
                r.reading_mv    = MV_W'(avg * MV_NUM / MV_DEN);
                flt_index = '0;
                flt_sum   = '0;
                flt_max   = '0;
                flt_min   = SAMPLE_MAX;
                apply_reading(r.reading_mv);
                readings_seen++;
            end
        end
        r.temp_state = th_state;
        r.confirming = cf_active;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Predict on every accepted input word, check every accepted output
    // word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_ready)
            stall_cycles++;
        if (rst_n && out_valid && out_ready) begin
            if (predicted_status.size() == 0) begin
                $error("status word with no input word pending: %p", out_word);
                mismatches++;
            end else begin
                want = predicted_status.pop_front();
                if (out_word.temp_state !== want.temp_state) begin
                    $error("temp_state: expected %0d, got %0d",
                           want.temp_state, out_word.temp_state);
                    mismatches++;
                end
                if (out_word.reading_valid !== want.reading_valid) begin
                    $error("reading_valid: expected %0d, got %0d",
                           want.reading_valid, out_word.reading_valid);
                    mismatches++;
                end
                if (out_word.reading_mv !== want.reading_mv) begin
                    $error("reading_mv: expected %0d, got %0d",
                           want.reading_mv, out_word.reading_mv);
                    mismatches++;
                end
                if (out_word.confirming !== want.confirming) begin
                    $error("confirming: expected %0d, got %0d",
                           want.confirming, out_word.confirming);
                    mismatches++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            predicted_status.push_back(monitor_step(in_word));
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Offer one word after a random gap; hold it until it is taken.
    // Returns just after the accepting edge.
    task automatic send_word(t_in_word w);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99, 0) < snd_idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_tick();
        send_word(t_in_word'{OP_TICK, 12'($urandom)});
    endtask

    // One full reading group with samples in [lo, hi] and random ticks mixed in
    task automatic send_group(int unsigned lo, int unsigned hi, int unsigned tick_pct);
        for (int n = 0; n < GROUP_SIZE; n++) begin
            while ($urandom_range(99, 0) < tick_pct)
                send_tick();
            send_word(t_in_word'{OP_SAMPLE, 12'($urandom_range(hi, lo))});
        end
    endtask

    // Pick a group aimed below or above the threshold, with some rail and
    // full-range noise groups
    task automatic send_random_group(int unsigned below_pct, int unsigned tick_pct);
        int unsigned pick;
        int unsigned mv;
        int unsigned lvl;
        int unsigned spread;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(99, 0);
        if (pick < 4) begin
            lo = 0;
            hi = 0;
        end else if (pick < 8) begin
            lo = SAMPLE_MAX;
            hi = SAMPLE_MAX;
        end else if (pick < 16) begin
            lo = 0;
            hi = SAMPLE_MAX;
        end else begin
            if ($urandom_range(99, 0) < below_pct)
                mv = (thr_mv > 400) ? thr_mv - $urandom_range(400, 1)
                                    : $urandom_range(thr_mv, 0);
            else
                mv = thr_mv + $urandom_range(400, 1);
            if (mv > MV_FULL_SCALE)
                mv = MV_FULL_SCALE;
            lvl    = mv * MV_DEN / MV_NUM;
            spread = $urandom_range(60, 0);
            lo     = (lvl > spread) ? lvl - spread : 0;
            hi     = (lvl + spread > SAMPLE_MAX) ? SAMPLE_MAX : lvl + spread;
        end
        send_group(lo, hi, tick_pct);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; only called while the block is idle
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_HOT_THRESHOLD: thr_mv       = MV_W'(value);
            CFG_HOLD_TICKS:    hold_limit   = TICK_W'(value);
            CFG_CONFIRM:       confirm_need = COUNT_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int unsigned snd_pct, int unsigned rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes at reset values: ticks with full and empty sample
    // fields, a dropped zero sample that would otherwise win the minimum,
    // and a full-scale group that gives the top reading
    task automatic test_extremes();
        send_word(t_in_word'{OP_TICK, 12'hFFF});
        send_word(t_in_word'{OP_SAMPLE, 12'h000});
        send_word(t_in_word'{OP_SAMPLE, 12'hAAA});
        for (int n = 0; n < GROUP_SIZE - 2; n++) begin
            if (n == 9)
                send_word(t_in_word'{OP_TICK, 12'h555});
            send_word(t_in_word'{OP_SAMPLE, SAMPLE_MAX});
        end
        send_word(t_in_word'{OP_TICK, 12'h000});
    endtask

    // Zero threshold: nothing is strictly below, so no confirmation opens,
    // not even for a zero reading
    task automatic test_no_trigger();
        settle();
        set_reg(CFG_HOT_THRESHOLD, 0);
        set_reg(CFG_CONFIRM, 15);
        set_reg(CFG_HOLD_TICKS, TIMER_MAX);
        send_group(0, 0, 0);
        repeat (4) send_random_group(50, 10);
    endtask

    // Normal-state confirmations with aborts; once hot, the maximum hold
    // keeps every reading ignored
    task automatic test_normal_confirm();
        settle();
        set_reg(CFG_HOT_THRESHOLD, 2500);
        set_reg(CFG_CONFIRM, 3);
        repeat (8) send_random_group(70, 10);
    endtask

    // Short hold with tick bursts: the hot confirmation runs, aborts and
    // restarts
    task automatic test_hot_hold();
        settle();
        set_reg(CFG_HOT_THRESHOLD, $urandom_range(3500, 1500));
        set_reg(CFG_HOLD_TICKS, 12);
        set_reg(CFG_CONFIRM, 4);
        repeat (8) begin
            send_random_group(60, 10);
            repeat ($urandom_range(6, 0)) send_tick();
        end
    endtask

    // Sink holds off while words keep coming, so the pipeline fills and
    // input ready drops
    task automatic test_backpressure();
        settle();
        set_reg(CFG_HOT_THRESHOLD, 3000);
        set_reg(CFG_CONFIRM, 0);
        @(posedge clk);
        hold_request = 60;
        repeat (2) send_random_group(50, 5);
        repeat (2) send_random_group(50, 5);
    endtask

    // Full-scale threshold and no hold: drive into the latch, then keep
    // reading with the state frozen
    task automatic test_latch();
        settle();
        set_reg(CFG_HOT_THRESHOLD, MV_FULL_SCALE);
        set_reg(CFG_HOLD_TICKS, 0);
        set_reg(CFG_CONFIRM, 2);
        repeat (6) send_random_group(90, 5);
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        set_idling(16, 45);
        test_extremes();
        test_no_trigger();
        test_normal_confirm();

        set_idling(45, 16);
        test_hot_hold();

        set_idling(0, 0);
        test_backpressure();
        test_latch();

        settle();
        repeat (8) @(posedge clk);

        $display("covered %0d readings and %0d ticks over threshold, hold and confirm values",
                 readings_seen, ticks_seen);
        $display("entered hot %0d time(s), latched %0d time(s), input stalled %0d cycles",
                 hot_entries, latch_entries, stall_cycles);
        if (mismatches == 0)
            $display("tb_overtemp_trimmed_mean_monitor OK");
        else
            $display("tb_overtemp_trimmed_mean_monitor NOT OK");
        $finish;
    end

endmodule

/* overtemp_trimmed_mean_monitor.f */
rtl/core/ovtm_pkg.sv
rtl/core/ovtm_filter.sv
rtl/core/ovtm_thermal.sv
rtl/core/overtemp_trimmed_mean_monitor.sv
sim/tb_overtemp_trimmed_mean_monitor.sv
